// File: rtl/core/mlp_pkg.sv
package mlp_pkg;

  // Number of row or column positions that the 6-bit index fields can address.
  localparam int unsigned IndexLimit = 64;

  localparam int unsigned InputCountDefault  = 64;
  localparam int unsigned HiddenCountDefault = 64;
  localparam int unsigned OutputCountDefault = 64;

  // Action codes of an input transaction.
  localparam logic [1:0] ActWeight1 = 2'd0;
  localparam logic [1:0] ActWeight2 = 2'd1;
  localparam logic [1:0] ActSample  = 2'd2;
  localparam logic [1:0] ActInvalid = 2'd3;

  // Half of one Q4.12 step in the Q4.28 product sum, added before the shift.
  localparam logic [16:0] RoundHalf = 17'd32768;

  localparam logic [63:0] ExpStepQ32 = 64'd4034748382;

  typedef logic [255:0][15:0] sig_rom_t;

  // Rounded quotient by shift and subtract, capped at the 16-bit maximum.
  function automatic logic [15:0] round_div_cap(logic [63:0] num, logic [63:0] den);
    logic [63:0] n;
    logic [64:0] rem;
    logic [63:0] q;
    n   = num + (den >> 1);
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return (q > 64'd65535) ? 16'hFFFF : q[15:0];
  endfunction

  // Sigmoid table over x = (t - 128) / 16, built once at elaboration.
  function automatic sig_rom_t build_sig_rom();
    sig_rom_t   rom;
    logic [63:0] e;
    logic [63:0] den;
    rom = '0;
    e   = 64'd1 << 32;
    for (int m = 0; m <= 128; m++) begin
      den = (64'd1 << 32) + e;
      if (m <= 127) rom[128 + m] = round_div_cap(64'd1 << 48, den);
      if (m >= 1) rom[128 - m] = round_div_cap(e << 16, den);
      e = (e * ExpStepQ32 + (64'd1 << 31)) >> 32;
    end
    return rom;
  endfunction

  localparam sig_rom_t SigRom = build_sig_rom();

  function automatic logic signed [15:0] sat16(logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sh7FFF;
    if (v < -64'sd32768) return -16'sh8000;
    return v[15:0];
  endfunction

  // Table index is (s + 32768) >> 8, which is the top byte with its sign flipped.
  function automatic logic [15:0] sigmoid(logic signed [15:0] s);
    return SigRom[{~s[15], s[14:8]}];
  endfunction

endpackage

// File: rtl/core/mlp_stream_if.sv
interface mlp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [5:0]  row_index;
  logic [5:0]  column_index;
  logic signed [15:0] weight_value;
  logic        sample_bit;
  logic        sample_last;

  modport source (output valid, action, row_index, column_index, weight_value,
                  sample_bit, sample_last, input ready);
  modport sink (input valid, action, row_index, column_index, weight_value,
                sample_bit, sample_last, output ready);
endinterface

interface mlp_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  output_index;
  logic [15:0] activation;
  logic        last_output;

  modport source (output valid, output_index, activation, last_output, input ready);
  modport sink (input valid, output_index, activation, last_output, output ready);
endinterface

// File: rtl/core/mlp_ram.sv
module mlp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/mlp_cell.sv
module mlp_cell #(
  parameter int unsigned Width = 22
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [Width-1:0] d_i,
  output logic signed [Width-1:0] q_o
);

  logic signed [Width-1:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (en_i) acc_q <= d_i;
  end

  assign q_o = acc_q;

endmodule

// File: rtl/core/two_layer_mlp_forward.sv
// Forward pass of a two-layer perceptron with sigmoid activations. Weight
// transactions are each written into one of two weight RAMs; sample
// transactions store one input bit, and the sample flagged last starts an
// evaluation during which no input is taken. The input stays blocked until
// the last result has been loaded into the output register. The weight RAMs
// are read at one weight per cycle. Partial sums live in two rings of
// accumulator cells, one cell per hidden node and one per output node,
// which rotate by one cell for every weight read, so the adder at each
// ring's head always meets the sum of the node whose weight arrives.
// Results leave through an output register in ascending node order, the
// final one carrying last_output.
module two_layer_mlp_forward #(
  parameter int unsigned INPUT_COUNT  = mlp_pkg::InputCountDefault,
  parameter int unsigned HIDDEN_COUNT = mlp_pkg::HiddenCountDefault,
  parameter int unsigned OUTPUT_COUNT = mlp_pkg::OutputCountDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  mlp_in_if.sink   in_i,
  mlp_out_if.source out_o
);

  // Rows and columns beyond the index range are never written and count as zero,
  // so they are simply not visited.
  localparam int unsigned R1  = (INPUT_COUNT < mlp_pkg::IndexLimit) ?
                                INPUT_COUNT : mlp_pkg::IndexLimit;
  localparam int unsigned N1  = (HIDDEN_COUNT < mlp_pkg::IndexLimit) ?
                                HIDDEN_COUNT : mlp_pkg::IndexLimit;
  localparam int unsigned N2  = OUTPUT_COUNT;
  localparam int unsigned RB  = (R1 > 1) ? $clog2(R1) : 1;
  localparam int unsigned HB  = (N1 > 1) ? $clog2(N1) : 1;
  localparam int unsigned OB  = (N2 > 1) ? $clog2(N2) : 1;
  localparam int unsigned AW1 = 17 + RB;
  localparam int unsigned AW2 = 34 + HB;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StL1    = 3'd1;
  localparam logic [2:0] StGap   = 3'd2;
  localparam logic [2:0] StL2    = 3'd3;
  localparam logic [2:0] StDrain = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [RB-1:0] i_q, i_d;
  logic [HB-1:0] j_q, j_d;
  logic [OB-1:0] k_q, k_d;
  logic          drain_q, drain_d;

  logic in_fire;
  assign in_i.ready = (state_q == StIdle);
  assign in_fire    = in_i.valid && in_i.ready;

  // Weight and sample stores.
  logic            w1_we, w2_we, s_we;
  logic [15:0]     w1_rd, w2_rd;
  logic [0:0]      s_rd;
  logic [RB+HB-1:0] w1_raddr;
  logic [HB+OB-1:0] w2_raddr;

  assign w1_we = in_fire && (in_i.action == mlp_pkg::ActWeight1) &&
                 (32'(in_i.row_index) < INPUT_COUNT) && (32'(in_i.column_index) < HIDDEN_COUNT);
  assign w2_we = in_fire && (in_i.action == mlp_pkg::ActWeight2) &&
                 (32'(in_i.row_index) < HIDDEN_COUNT) && (32'(in_i.column_index) < OUTPUT_COUNT);
  assign s_we  = in_fire && (in_i.action == mlp_pkg::ActSample) &&
                 (32'(in_i.row_index) < INPUT_COUNT);

  assign w1_raddr = {i_q, j_q};
  assign w2_raddr = {j_q, k_q};

  mlp_ram #(.Width(16), .Depth(2 ** (RB + HB))) u_w1_ram (
    .clk_i   (clk_i),
    .we_i    (w1_we),
    .waddr_i ({in_i.row_index[RB-1:0], in_i.column_index[HB-1:0]}),
    .wdata_i (in_i.weight_value),
    .raddr_i (w1_raddr),
    .rdata_o (w1_rd)
  );

  mlp_ram #(.Width(16), .Depth(2 ** (HB + OB))) u_w2_ram (
    .clk_i   (clk_i),
    .we_i    (w2_we),
    .waddr_i ({in_i.row_index[HB-1:0], in_i.column_index[OB-1:0]}),
    .wdata_i (in_i.weight_value),
    .raddr_i (w2_raddr),
    .rdata_o (w2_rd)
  );

  mlp_ram #(.Width(1), .Depth(2 ** RB)) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (in_i.row_index[RB-1:0]),
    .wdata_i (in_i.sample_bit),
    .raddr_i (i_q),
    .rdata_o (s_rd)
  );

  // Pipeline flags: v1 marks a first-layer weight arriving from RAM, v2b a
  // second-layer weight arriving, v2c a registered product ready for the ring.
  logic v1_q, first1_q, v2b_q, first2b_q, v2c_q, first2c_q;
  logic [15:0] h_q;
  logic signed [33:0] prod_q;

  // Hidden ring.
  logic signed [AW1-1:0] r1 [N1];
  logic signed [AW1-1:0] r1_head;
  logic signed [AW1-1:0] r1_term;
  logic                  r1_en;
  logic                  h_load;

  assign h_load  = (state_q == StL2) && (k_q == '0);
  assign r1_term = s_rd[0] ? AW1'($signed(w1_rd)) : '0;
  assign r1_head = v1_q ? ((first1_q ? '0 : r1[N1-1]) + r1_term) : r1[N1-1];
  assign r1_en   = v1_q || h_load;

  for (genvar c = 0; c < N1; c++) begin : g_hidden
    mlp_cell #(.Width(AW1)) u_cell (
      .clk_i (clk_i),
      .en_i  (r1_en),
      .d_i   ((c == 0) ? r1_head : r1[(c == 0) ? 0 : c - 1]),
      .q_o   (r1[c])
    );
  end

  // Output ring.
  logic signed [AW2-1:0] r2 [N2];
  logic signed [AW2-1:0] r2_head;
  logic                  r2_en;
  logic                  out_load;

  assign r2_head = v2c_q ? ((first2c_q ? '0 : r2[N2-1]) + AW2'(prod_q)) : r2[N2-1];
  assign r2_en   = v2c_q || out_load;

  for (genvar c = 0; c < N2; c++) begin : g_output
    mlp_cell #(.Width(AW2)) u_cell (
      .clk_i (clk_i),
      .en_i  (r2_en),
      .d_i   ((c == 0) ? r2_head : r2[(c == 0) ? 0 : c - 1]),
      .q_o   (r2[c])
    );
  end

  // Round the Q4.28 sum to Q4.12: add half a step, then shift towards minus infinity.
  logic signed [AW2:0] r2_round;
  logic signed [AW2:0] r2_q412;
  assign r2_round = (AW2 + 1)'(r2[N2-1]) + (AW2 + 1)'($signed({1'b0, mlp_pkg::RoundHalf}));
  assign r2_q412  = r2_round >>> 16;

  logic        out_valid_q;
  logic [5:0]  out_index_q;
  logic [15:0] out_act_q;
  logic        out_last_q;

  assign out_load = (state_q == StOut) && (!out_valid_q || out_o.ready);

  // Sequencer over the two weight matrices and the result list.
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    drain_d = drain_q;
    case (state_q)
      StIdle: begin
        if (in_fire && (in_i.action == mlp_pkg::ActSample) && in_i.sample_last) begin
          state_d = StL1;
          i_d     = '0;
          j_d     = '0;
        end
      end
      StL1: begin
        if (j_q == HB'(N1 - 1)) begin
          j_d = '0;
          if (i_q == RB'(R1 - 1)) state_d = StGap;
          else i_d = i_q + 1'b1;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      StGap: begin
        state_d = StL2;
        j_d     = '0;
        k_d     = '0;
      end
      StL2: begin
        if (k_q == OB'(N2 - 1)) begin
          k_d = '0;
          if (j_q == HB'(N1 - 1)) begin
            state_d = StDrain;
            drain_d = 1'b0;
          end else begin
            j_d = j_q + 1'b1;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      StDrain: begin
        drain_d = 1'b1;
        if (drain_q) begin
          state_d = StOut;
          k_d     = '0;
        end
      end
      StOut: begin
        if (out_load) begin
          if (k_q == OB'(N2 - 1)) state_d = StIdle;
          else k_d = k_q + 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      drain_q     <= 1'b0;
      v1_q        <= 1'b0;
      v2b_q       <= 1'b0;
      v2c_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      drain_q <= drain_d;
      v1_q    <= (state_q == StL1);
      v2b_q   <= (state_q == StL2);
      v2c_q   <= v2b_q;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    first1_q  <= (i_q == '0);
    first2b_q <= (j_q == '0);
    first2c_q <= first2b_q;
    // The hidden activation for row j is taken as the ring's tail passes by.
    if (h_load) h_q <= mlp_pkg::sigmoid(mlp_pkg::sat16(64'(r1[N1-1])));
    if (v2b_q) prod_q <= $signed({1'b0, h_q}) * $signed(w2_rd);
    if (out_load) begin
      out_index_q <= 6'(k_q);
      out_act_q   <= mlp_pkg::sigmoid(mlp_pkg::sat16(64'(r2_q412)));
      out_last_q  <= (k_q == OB'(N2 - 1));
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.output_index = out_index_q;
  assign out_o.activation   = out_act_q;
  assign out_o.last_output  = out_last_q;

  // The two accumulation rings are never fed in the same cycle.
  a_rings_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(v1_q && (v2b_q || v2c_q)))
    else $error("first- and second-layer accumulation overlap");

  // New transactions are taken only once the pipeline has drained.
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (!v1_q && !v2b_q && !v2c_q))
    else $error("input accepted while an evaluation is in flight");

  // A result is loaded only when the previous one has been taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_index_q)))
    else $error("pending result overwritten");

  // The flagged result is the final output node.
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_index_q == 6'(N2 - 1)))
    else $error("last flag on the wrong output node");

endmodule

// File: tb/tb_two_layer_mlp_forward.sv
`timescale 1ns / 1ps

module tb_two_layer_mlp_forward;

  // The run is bounded by the evaluations. Each one includes the receiver
  // stalls that its 64 results wait out. The limit covers every one of the
  // roughly 8800 transactions starting an evaluation, several times over.
  localparam int unsigned CycleLimit = 400_000_000;
  localparam int unsigned NodeCount  = 64;

  typedef struct {
    logic [1:0]         action;
    logic [5:0]         row_index;
    logic [5:0]         column_index;
    logic signed [15:0] weight_value;
    logic               sample_bit;
    logic               sample_last;
  } mlp_item_t;

  typedef struct {
    logic [5:0]  output_index;
    logic [15:0] activation;
    logic        last_output;
  } node_result_t;

  logic clk_i;
  logic rst_ni;

  mlp_in_if  in_if ();
  mlp_out_if out_if ();

  two_layer_mlp_forward i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Our own image of the network. It is updated at each accepted input
  // transaction, in the same order as the block sees them.
  logic signed [15:0] hidden_weights [NodeCount][NodeCount];
  logic signed [15:0] output_weights [NodeCount][NodeCount];
  logic               sample_bits    [NodeCount];
  logic        [15:0] sigmoid_table  [256];

  node_result_t activation_queue[$];

  int unsigned cycle_count;
  int unsigned error_count;

  // When set, the matching side runs without any idle cycles.
  logic sender_busy_mode;
  logic receiver_busy_mode;

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL two_layer_mlp_forward");
      $finish;
    end
  end

  // The sigmoid table is rebuilt here from its definition. Entry t stands
  // for x = (t - 128) / 16. E(m) = e^(-m/16) is kept in Q32.32 and is
  // stepped by a fixed multiply. Each entry is rounded half up and capped.
  function automatic logic [15:0] rounded_ratio(longint unsigned num, longint unsigned den);
    longint unsigned q;
    q = (num + den / 2) / den;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  task automatic fill_sigmoid_table();
    longint unsigned e_q32;
    longint unsigned den;
    e_q32 = 64'd1 << 32;
    for (int m = 0; m <= 128; m++) begin
      den = (64'd1 << 32) + e_q32;
      if (m <= 127) sigmoid_table[128 + m] = rounded_ratio(64'd1 << 48, den);
      if (m >= 1) sigmoid_table[128 - m] = rounded_ratio(e_q32 << 16, den);
      e_q32 = (e_q32 * 64'd4034748382 + (64'd1 << 31)) >> 32;
    end
  endtask

  function automatic logic [15:0] sigmoid_of_sum(longint sum);
    longint clipped;
    clipped = (sum > 32767) ? 32767 : (sum < -32768) ? -32768 : sum;
    return sigmoid_table[(clipped + 32768) >> 8];
  endfunction

  // A full forward pass. The hidden sums add the first-layer weights of set
  // inputs. The output sums are Q4.28 products, rounded to Q4.12 by adding
  // one half and shifting right arithmetically, which floors.
  task automatic predict_forward_pass();
    logic [15:0] hidden_act [NodeCount];
    longint      acc;
    node_result_t r;
    for (int j = 0; j < NodeCount; j++) begin
      acc = 0;
      for (int i = 0; i < NodeCount; i++)
        if (sample_bits[i]) acc += longint'(hidden_weights[i][j]);
      hidden_act[j] = sigmoid_of_sum(acc);
    end
    for (int k = 0; k < NodeCount; k++) begin
      acc = 0;
      for (int j = 0; j < NodeCount; j++)
        acc += longint'({48'd0, hidden_act[j]}) * longint'(output_weights[j][k]);
      acc = (acc + 32768) >>> 16;
      r.output_index = k[5:0];
      r.activation   = sigmoid_of_sum(acc);
      r.last_output  = (k == NodeCount - 1);
      activation_queue.push_back(r);
    end
  endtask

  task automatic apply_to_network(mlp_item_t it);
    case (it.action)
      mlp_pkg::ActWeight1: hidden_weights[it.row_index][it.column_index] = it.weight_value;
      mlp_pkg::ActWeight2: output_weights[it.row_index][it.column_index] = it.weight_value;
      mlp_pkg::ActSample: begin
        sample_bits[it.row_index] = it.sample_bit;
        if (it.sample_last) predict_forward_pass();
      end
      default: ;
    endcase
  endtask

  // Sends one transaction after a random gap. valid is lowered only when a
  // gap follows, so back-to-back transactions keep it high without a glitch.
  task automatic send_item(mlp_item_t it);
    int gap;
    gap = sender_busy_mode ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.action       <= it.action;
    in_if.row_index    <= it.row_index;
    in_if.column_index <= it.column_index;
    in_if.weight_value <= it.weight_value;
    in_if.sample_bit   <= it.sample_bit;
    in_if.sample_last  <= it.sample_last;
    do @(posedge clk_i); while (!in_if.ready);
    apply_to_network(it);
  endtask

  function automatic mlp_item_t make_item(logic [1:0] action, int row, int col,
                                          int weight, logic sample_bit, logic sample_last);
    mlp_item_t it;
    it.action       = action;
    it.row_index    = row[5:0];
    it.column_index = col[5:0];
    it.weight_value = weight[15:0];
    it.sample_bit   = sample_bit;
    it.sample_last  = sample_last;
    return it;
  endfunction

  // Mostly modest weights, so that sums land inside the sigmoid range,
  // with full-range values now and then to hit saturation.
  function automatic int draw_weight();
    if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 2047)) - 1024;
  endfunction

  // The receiver holds ready low for a random number of cycles before each
  // result, with occasional stretches where it never stalls.
  initial begin
    int stall;
    int taken;
    out_if.ready       = 1'b0;
    receiver_busy_mode = 1'b0;
    taken              = 0;
    forever begin
      stall = receiver_busy_mode ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
      taken++;
      if (taken % 50 == 0) receiver_busy_mode = ($urandom_range(0, 2) == 0);
    end
  end

  // Every result transaction is compared with the oldest expected one.
  always @(posedge clk_i) begin
    node_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (activation_queue.size() == 0) begin
        $display("%0t: unexpected result: index %0d activation %h last %b", $time,
                 out_if.output_index, out_if.activation, out_if.last_output);
        error_count++;
      end else begin
        want = activation_queue.pop_front();
        if (out_if.output_index !== want.output_index) begin
          $display("%0t: output_index expected %0d actual %0d", $time,
                   want.output_index, out_if.output_index);
          error_count++;
        end
        if (out_if.activation !== want.activation) begin
          $display("%0t: activation of node %0d expected %h actual %h", $time,
                   want.output_index, want.activation, out_if.activation);
          error_count++;
        end
        if (out_if.last_output !== want.last_output) begin
          $display("%0t: last_output of node %0d expected %b actual %b", $time,
                   want.output_index, want.last_output, out_if.last_output);
          error_count++;
        end
      end
    end
  end

  // Both weight matrices and the whole sample store must be written before
  // the first evaluation, since unwritten entries have no defined value.
  task automatic test_fill_network();
    sender_busy_mode = 1'b1;
    for (int i = 0; i < NodeCount; i++)
      for (int j = 0; j < NodeCount; j++) begin
        send_item(make_item(mlp_pkg::ActWeight1, i, j, draw_weight(), $urandom_range(0, 1),
                            $urandom_range(0, 1)));
        send_item(make_item(mlp_pkg::ActWeight2, i, j, draw_weight(), $urandom_range(0, 1),
                            $urandom_range(0, 1)));
      end
    for (int i = 0; i < NodeCount; i++)
      send_item(make_item(mlp_pkg::ActSample, i, $urandom_range(0, 63), draw_weight(),
                          $urandom_range(0, 1), 1'b0));
    sender_busy_mode = 1'b0;
  endtask

  // Extremes of the fields, the ignored cases and both saturation limits.
  task automatic test_directed();
    // Only input 0 set: hidden node 0 sees the largest weight and node 63
    // the most negative one.
    for (int i = 0; i < NodeCount; i++)
      send_item(make_item(mlp_pkg::ActSample, i, 0, 0, (i == 0), 1'b0));
    send_item(make_item(mlp_pkg::ActWeight1, 0, 0, 32767, 1'b0, 1'b1));
    send_item(make_item(mlp_pkg::ActWeight1, 0, 63, -32768, 1'b1, 1'b0));
    send_item(make_item(mlp_pkg::ActWeight2, 63, 0, 32767, 1'b1, 1'b1));
    send_item(make_item(mlp_pkg::ActWeight2, 0, 63, -32768, 1'b0, 1'b0));
    // An unknown action with every field set must change nothing.
    send_item(make_item(mlp_pkg::ActInvalid, 63, 63, -1, 1'b1, 1'b1));
    send_item(make_item(mlp_pkg::ActSample, 63, 63, -1, 1'b0, 1'b1));
    // All inputs set, last element arriving at position 0.
    for (int i = NodeCount - 1; i >= 0; i--)
      send_item(make_item(mlp_pkg::ActSample, i, 0, 0, 1'b1, (i == 0)));
    // All inputs clear: every hidden node sits at the sigmoid of zero.
    for (int i = 0; i < NodeCount; i++)
      send_item(make_item(mlp_pkg::ActSample, i, 63, 0, 1'b0, (i == NodeCount - 1)));
  endtask

  task automatic test_random(int item_total);
    int pick;
    for (int n = 0; n < item_total; n++) begin
      if (n % 40 == 0) sender_busy_mode = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 40)
        send_item(make_item(mlp_pkg::ActWeight1, $urandom_range(0, 63), $urandom_range(0, 63),
                            draw_weight(), $urandom_range(0, 1), $urandom_range(0, 1)));
      else if (pick < 65)
        send_item(make_item(mlp_pkg::ActWeight2, $urandom_range(0, 63), $urandom_range(0, 63),
                            draw_weight(), $urandom_range(0, 1), $urandom_range(0, 1)));
      else if (pick < 95)
        send_item(make_item(mlp_pkg::ActSample, $urandom_range(0, 63), $urandom_range(0, 63),
                            draw_weight(), $urandom_range(0, 1),
                            ($urandom_range(0, 7) == 0)));
      else
        send_item(make_item(mlp_pkg::ActInvalid, $urandom_range(0, 63), $urandom_range(0, 63),
                            draw_weight(), $urandom_range(0, 1), $urandom_range(0, 1)));
    end
    // Close with one evaluation so the last changes are observed.
    send_item(make_item(mlp_pkg::ActSample, $urandom_range(0, 63), $urandom_range(0, 63),
                        draw_weight(), $urandom_range(0, 1), 1'b1));
  endtask

  initial begin
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    cycle_count        = 0;
    error_count        = 0;
    sender_busy_mode   = 1'b0;
    in_if.valid        = 1'b0;
    in_if.action       = mlp_pkg::ActSample;
    in_if.row_index    = '0;
    in_if.column_index = '0;
    in_if.weight_value = '0;
    in_if.sample_bit   = 1'b0;
    in_if.sample_last  = 1'b0;
    fill_sigmoid_table();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_fill_network();
    test_directed();
    test_random(300);

    in_if.valid <= 1'b0;
    while (activation_queue.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (error_count == 0) begin
      $display("PASS two_layer_mlp_forward");
    end else begin
      $display("FAIL two_layer_mlp_forward");
    end
    $finish;
  end

endmodule
